[rtl/melg_pkg.sv]
// shared constants and mask helpers for the melg recurrence step core
package melg_pkg;

	// item function codes
	localparam logic FUNC_GEN  = 1'b0;
	localparam logic FUNC_LOAD = 1'b1;

	// configuration register indexes (byte address is 8 times the index)
	localparam logic [2:0] REG_WORD_WIDTH     = 3'd0;
	localparam logic [2:0] REG_MID_OFFSET     = 3'd1;
	localparam logic [2:0] REG_SPLIT_BITS     = 3'd2;
	localparam logic [2:0] REG_LEFT_SHIFT     = 3'd3;
	localparam logic [2:0] REG_RIGHT_SHIFT    = 3'd4;
	localparam logic [2:0] REG_TWIST_CONSTANT = 3'd5;

	// configuration reset values
	localparam logic [6:0] WORD_WIDTH_RST  = 7'd64;
	localparam logic [8:0] MID_OFFSET_RST  = 9'd1;
	localparam logic [5:0] SPLIT_BITS_RST  = 6'd0;
	localparam logic [5:0] LEFT_SHIFT_RST  = 6'd1;
	localparam logic [5:0] RIGHT_SHIFT_RST = 6'd1;

	localparam int WORD_BITS = 64;

	typedef logic [WORD_BITS-1:0] word_t;

	// mask of the active word bits; zero width acts as one bit, wide settings saturate
	function automatic word_t width_mask(input logic [6:0] w);
		word_t m;
		begin
			if (w == 7'd0) begin
				m = word_t'(1);
			end else if (w >= 7'd64) begin
				m = '1;
			end else begin
				m = (word_t'(1) << w[5:0]) - word_t'(1);
			end
			return m;
		end
	endfunction

	// low r bits of the word that come from the next ring word
	function automatic word_t low_mask(input logic [5:0] r, input word_t wm);
		return ((word_t'(1) << r) - word_t'(1)) & wm;
	endfunction

endpackage

[rtl/melg_recurrence_step_core.sv]
// melg recurrence step core: ring memory, tap forwarding, twist and xor-shift datapath
// A generate transaction is registered in stage 1; its word is then registered onto random_word.
// Throughput: one transaction per cycle barring output stalls, set by the extra word register loop.
// The ring lives in a memory with one write and two read ports; word i comes from the previous read.
// Reset clears the ring position, the pipeline valids and the configuration registers.
// Ring memory contents are not cleared; every word must be seeded before generating.
module melg_recurrence_step_core #(
	parameter int STATE_WORDS = 312
) (
	input  logic               clk,
	input  logic               arst_n,
	// input channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic               func,
	input  logic [8:0]         word_index,
	input  melg_pkg::word_t    load_value,
	// output channel
	output logic               out_valid,
	input  logic               out_stall,
	output melg_pkg::word_t    random_word,
	// configuration port
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [5:0]         paddr,
	input  logic [63:0]        pwdata,
	output logic [63:0]        prdata,
	output logic               pready
);
	import melg_pkg::*;

	localparam int RING_LEN = STATE_WORDS - 1;
	localparam int PW       = $clog2(RING_LEN);
	localparam int IW       = 11;

	// configuration registers
	logic [6:0]    word_width_q;
	logic [8:0]    mid_offset_q;
	logic [5:0]    split_bits_q;
	logic [5:0]    left_shift_q;
	logic [5:0]    right_shift_q;
	word_t         twist_constant_q;
	logic [PW-1:0] mid_mod_q;

	// front end
	logic [PW-1:0] pos_q;
	logic [PW-1:0] pos_inc;
	logic [PW:0]   mid_sum;
	logic [PW-1:0] pos_mid;
	logic          accept;

	// stage 1
	logic          valid_s1;
	logic          func_s1;
	logic [8:0]    idx_s1;
	word_t         value_s1;
	logic [PW-1:0] pos_s1;
	logic          s1_adv;
	logic          out_free;

	// memory and forwarding
	word_t         ring_mem [RING_LEN];
	word_t         rd_a_q;
	word_t         rd_b_q;
	logic          fwd_a_q;
	logic          fwd_b_q;
	word_t         fwd_data_q;
	logic          wr_en;
	logic [PW-1:0] wr_addr;
	word_t         wr_data;

	// state words held beside the memory
	word_t         next_cur_q;
	word_t         w0_q;
	word_t         extra_q;

	// output register
	logic          out_valid_q;
	word_t         random_word_q;

	// datapath
	word_t         wm;
	word_t         lo;
	word_t         hi;
	word_t         val_m;
	word_t         wi1_raw;
	word_t         wmid_raw;
	word_t         wi;
	word_t         wi1;
	word_t         wmid;
	word_t         v;
	word_t         x;
	word_t         xa;
	word_t         vb;
	word_t         vnew;
	word_t         vc;
	word_t         neww;
	logic [IW-1:0] idx_ext;
	logic          idx_zero;
	logic          idx_ring;
	logic          idx_extra;

	// mid offset reduction tables, built at elaboration
	logic [PW-1:0] hi_tab [8];
	logic [PW-1:0] lo_tab [64];
	logic [PW:0]   cfg_mod_sum;
	logic [PW-1:0] cfg_mid_mod;
	logic          cfg_wr;

	for (genvar g = 0; g < 8; g++) begin : g_hi_tab
		assign hi_tab[g] = PW'((g * 64) % RING_LEN);
	end
	for (genvar g = 0; g < 64; g++) begin : g_lo_tab
		assign lo_tab[g] = PW'(g % RING_LEN);
	end

	// offset modulo ring length from the written value
	always_comb begin
		cfg_mod_sum = {1'b0, hi_tab[pwdata[8:6]]} + {1'b0, lo_tab[pwdata[5:0]]};
		if (cfg_mod_sum >= (PW+1)'(RING_LEN)) begin
			cfg_mid_mod = PW'(cfg_mod_sum - (PW+1)'(RING_LEN));
		end else begin
			cfg_mid_mod = PW'(cfg_mod_sum);
		end
	end

	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_width_q     <= WORD_WIDTH_RST;
			mid_offset_q     <= MID_OFFSET_RST;
			mid_mod_q        <= PW'(1);
			split_bits_q     <= SPLIT_BITS_RST;
			left_shift_q     <= LEFT_SHIFT_RST;
			right_shift_q    <= RIGHT_SHIFT_RST;
			twist_constant_q <= '0;
		end else if (cfg_wr) begin
			case (paddr[5:3])
				REG_WORD_WIDTH:     word_width_q <= pwdata[6:0];
				REG_MID_OFFSET: begin
					mid_offset_q <= pwdata[8:0];
					mid_mod_q    <= cfg_mid_mod;
				end
				REG_SPLIT_BITS:     split_bits_q     <= pwdata[5:0];
				REG_LEFT_SHIFT:     left_shift_q     <= pwdata[5:0];
				REG_RIGHT_SHIFT:    right_shift_q    <= pwdata[5:0];
				REG_TWIST_CONSTANT: twist_constant_q <= pwdata;
				default: ;
			endcase
		end
	end

	// register readback
	always_comb begin
		case (paddr[5:3])
			REG_WORD_WIDTH:     prdata = 64'(word_width_q);
			REG_MID_OFFSET:     prdata = 64'(mid_offset_q);
			REG_SPLIT_BITS:     prdata = 64'(split_bits_q);
			REG_LEFT_SHIFT:     prdata = 64'(left_shift_q);
			REG_RIGHT_SHIFT:    prdata = 64'(right_shift_q);
			REG_TWIST_CONSTANT: prdata = twist_constant_q;
			default:            prdata = '0;
		endcase
	end

	// handshake
	assign out_free = !out_valid_q || !out_stall;
	assign s1_adv   = (func_s1 == FUNC_LOAD) || out_free;
	assign in_stall = valid_s1 && !s1_adv;
	assign accept   = in_valid && !in_stall;

	// tap addresses for the next step
	always_comb begin
		pos_inc = (pos_q == PW'(RING_LEN - 1)) ? '0 : pos_q + PW'(1);
		mid_sum = {1'b0, pos_q} + {1'b0, mid_mod_q};
		if (mid_sum >= (PW+1)'(RING_LEN)) begin
			pos_mid = PW'(mid_sum - (PW+1)'(RING_LEN));
		end else begin
			pos_mid = PW'(mid_sum);
		end
	end

	// ring position and stage 1 control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				pos_q    <= (func == FUNC_LOAD) ? '0 : pos_inc;
				valid_s1 <= 1'b1;
			end else if (s1_adv) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	// stage 1 payload
	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1  <= func;
			idx_s1   <= word_index;
			value_s1 <= load_value;
			pos_s1   <= pos_q;
		end
	end

	// masks from the current configuration
	always_comb begin
		wm = width_mask(word_width_q);
		lo = low_mask(split_bits_q, wm);
		hi = wm & ~lo;
	end

	// load index decode
	always_comb begin
		idx_ext   = IW'(idx_s1);
		idx_zero  = (idx_s1 == 9'd0);
		idx_ring  = (idx_ext < IW'(RING_LEN));
		idx_extra = (idx_ext == IW'(RING_LEN));
		val_m     = value_s1 & wm;
	end

	// tap words with forwarding of the write that shared the read edge
	always_comb begin
		wi1_raw  = fwd_a_q ? fwd_data_q : rd_a_q;
		wmid_raw = fwd_b_q ? fwd_data_q : rd_b_q;
		wi       = next_cur_q & wm;
		wi1      = wi1_raw & wm;
		wmid     = wmid_raw & wm;
		v        = extra_q & wm;
	end

	// twist and xor-shift tempering of the step
	always_comb begin
		x  = (wi & hi) ^ (wi1 & lo);
		xa = x >> 1;
		if (x[0]) begin
			xa = xa ^ twist_constant_q;
		end
		xa   = xa & wm;
		vb   = (v ^ (v << left_shift_q)) & wm;
		vnew = (xa ^ wmid ^ vb) & wm;
		vc   = (vnew ^ (vnew >> right_shift_q)) & wm;
		neww = (x ^ vc) & wm;
	end

	// ring write port
	always_comb begin
		if (func_s1 == FUNC_LOAD) begin
			wr_en   = valid_s1 && idx_ring;
			wr_addr = PW'(idx_s1);
			wr_data = idx_zero ? (val_m & hi) : val_m;
		end else begin
			wr_en   = valid_s1 && out_free;
			wr_addr = pos_s1;
			wr_data = neww;
		end
	end

	// ring memory: one write, two registered reads
	always_ff @(posedge clk) begin
		if (wr_en) begin
			ring_mem[wr_addr] <= wr_data;
		end
		if (accept) begin
			rd_a_q     <= ring_mem[pos_inc];
			rd_b_q     <= ring_mem[pos_mid];
			fwd_a_q    <= wr_en && (wr_addr == pos_inc);
			fwd_b_q    <= wr_en && (wr_addr == pos_mid);
			fwd_data_q <= wr_data;
		end
	end

	// extra word, word zero shadow and the word at the ring position
	always_ff @(posedge clk) begin
		if (valid_s1 && s1_adv) begin
			if (func_s1 == FUNC_LOAD) begin
				if (idx_zero) begin
					w0_q       <= val_m & hi;
					next_cur_q <= val_m & hi;
				end else begin
					next_cur_q <= w0_q;
				end
				if (idx_extra) begin
					extra_q <= val_m;
				end
			end else begin
				extra_q    <= vnew;
				next_cur_q <= wi1_raw;
				if (pos_s1 == '0) begin
					w0_q <= neww;
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (valid_s1 && (func_s1 == FUNC_GEN) && out_free) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && (func_s1 == FUNC_GEN) && out_free) begin
			random_word_q <= neww;
		end
	end

	assign out_valid   = out_valid_q;
	assign random_word = random_word_q;

	// ring position and middle offset stay inside the ring
	a_pos_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, pos_q} < (PW+1)'(RING_LEN))
		else $error("ring position out of range");

	a_mid_range: assert property (@(posedge clk) disable iff (!arst_n)
		{1'b0, mid_mod_q} < (PW+1)'(RING_LEN))
		else $error("reduced middle offset out of range");

	// a finishing step always lands in the output register
	a_step_out: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && (func_s1 == FUNC_GEN) && s1_adv) |=> out_valid_q)
		else $error("step result lost");

	// stage 1 only holds when a full output register is stalled
	a_hold_cause: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s1_adv) |-> (out_valid_q && out_stall))
		else $error("stage 1 held without output backpressure");

	// a load transaction never produces a result
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && (func_s1 == FUNC_LOAD) && !out_valid_q) |=> !out_valid_q)
		else $error("load produced a result");

endmodule

[verif/melg_step_checker.sv]
// checker for the melg recurrence step core: tracks registers, predicts words, compares results
module melg_step_checker #(
	parameter int STATE_WORDS = 312
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	input  logic               in_stall,
	input  logic               func,
	input  logic [8:0]         word_index,
	input  melg_pkg::word_t    load_value,
	input  logic               out_valid,
	input  logic               out_stall,
	input  melg_pkg::word_t    random_word,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [5:0]         paddr,
	input  logic [63:0]        pwdata,
	input  logic               pready,
	output int                 mismatches,
	output int                 words_due
);
	timeunit 1ns;
	timeprecision 1ps;
	import melg_pkg::*;

	localparam int RING_LEN = STATE_WORDS - 1;

	// shadow copy of the generator state and its registers
	word_t       ring_mem [RING_LEN];
	word_t       extra_q;
	int unsigned ring_pos;
	logic [6:0]  cfg_width;
	logic [8:0]  cfg_mid;
	logic [5:0]  cfg_split;
	logic [5:0]  cfg_sl;
	logic [5:0]  cfg_sr;
	word_t       cfg_twist;

	// words still owed by the core, oldest first
	word_t pending_words[$];
	int    fail_count = 0;
	int    due_count = 0;

	assign mismatches = fail_count;
	assign words_due = due_count;

	// apply one input transaction to the shadow state; returns 1 when a word comes out
	function automatic bit advance_generator(input logic f, input logic [8:0] idx,
			input word_t val, output word_t produced);
		word_t       wm, lo, hi, x, xa, vb, vnew, vc, v;
		int unsigned nxt, mid;
		if (cfg_width == 7'd0) begin
			wm = word_t'(1);
		end else if (cfg_width >= 7'd64) begin
			wm = '1;
		end else begin
			wm = (word_t'(1) << cfg_width) - word_t'(1);
		end
		lo = ((word_t'(1) << cfg_split) - word_t'(1)) & wm;
		hi = wm & ~lo;
		produced = '0;

		// seed load: word zero keeps only its upper bits, out-of-range indexes are dropped
		if (f == FUNC_LOAD) begin
			if (idx == 9'd0) begin
				ring_mem[0] = val & hi;
			end else if (idx < RING_LEN) begin
				ring_mem[idx] = val & wm;
			end else if (idx == RING_LEN) begin
				extra_q = val & wm;
			end
			ring_pos = 0;
			return 1'b0;
		end

		// twist and xor-shift step
		nxt = (ring_pos + 1) % RING_LEN;
		mid = (ring_pos + cfg_mid) % RING_LEN;
		x = (ring_mem[ring_pos] & hi) ^ (ring_mem[nxt] & lo);
		xa = x >> 1;
		if (x[0]) begin
			xa = xa ^ cfg_twist;
		end
		xa = xa & wm;
		v = extra_q & wm;
		vb = (v ^ (v << cfg_sl)) & wm;
		vnew = (xa ^ (ring_mem[mid] & wm) ^ vb) & wm;
		vc = (vnew ^ (vnew >> cfg_sr)) & wm;
		produced = (x ^ vc) & wm;
		ring_mem[ring_pos] = produced;
		extra_q = vnew;
		ring_pos = nxt;
		return 1'b1;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		word_t produced;
		word_t expected_word;
		if (!arst_n) begin
			cfg_width = WORD_WIDTH_RST;
			cfg_mid = MID_OFFSET_RST;
			cfg_split = SPLIT_BITS_RST;
			cfg_sl = LEFT_SHIFT_RST;
			cfg_sr = RIGHT_SHIFT_RST;
			cfg_twist = '0;
			ring_pos = 0;
			pending_words.delete();
			due_count = 0;
		end else begin
			// result transaction against the oldest prediction
			if (out_valid && !out_stall) begin
				if (pending_words.size() == 0) begin
					fail_count++;
					$display("%0t: random_word %h arrived with nothing expected", $time,
						random_word);
				end else begin
					expected_word = pending_words.pop_front();
					if (random_word !== expected_word) begin
						fail_count++;
						$display("%0t: random_word expected %h actual %h", $time,
							expected_word, random_word);
					end
				end
			end

			// input transaction
			if (in_valid && !in_stall) begin
				if (advance_generator(func, word_index, load_value, produced)) begin
					pending_words.push_back(produced);
				end
			end

			// register write
			if (psel && penable && pwrite && pready) begin
				case (paddr[5:3])
					REG_WORD_WIDTH:     cfg_width = pwdata[6:0];
					REG_MID_OFFSET:     cfg_mid = pwdata[8:0];
					REG_SPLIT_BITS:     cfg_split = pwdata[5:0];
					REG_LEFT_SHIFT:     cfg_sl = pwdata[5:0];
					REG_RIGHT_SHIFT:    cfg_sr = pwdata[5:0];
					REG_TWIST_CONSTANT: cfg_twist = pwdata;
					default: ;
				endcase
			end
			due_count = pending_words.size();
		end
	end

endmodule

[verif/tb_melg_recurrence_step_core.sv]
// testbench top for the melg recurrence step core: clock, reset, stimulus and verdict
module tb_melg_recurrence_step_core;
	timeunit 1ns;
	timeprecision 1ps;
	import melg_pkg::*;

	localparam int STATE_WORDS = 312;
	localparam int RING_LEN = STATE_WORDS - 1;
	localparam int PHASES = 10;
	localparam int ITEMS_PER_PHASE = 160;
	localparam int CYCLE_LIMIT = 600000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        func;
	logic [8:0]  word_index;
	word_t       load_value;
	logic        out_valid;
	logic        out_stall = 1'b0;
	word_t       random_word;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [5:0]  paddr;
	logic [63:0] pwdata;
	logic [63:0] prdata;
	logic        pready;

	int mismatches;
	int words_due;
	int cycle_count = 0;
	int stall_hold = 0;
	bit no_gaps = 1'b0;

	melg_recurrence_step_core #(
		.STATE_WORDS(STATE_WORDS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.word_index(word_index),
		.load_value(load_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.random_word(random_word),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	melg_step_checker #(
		.STATE_WORDS(STATE_WORDS)
	) checker_i (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.func(func),
		.word_index(word_index),
		.load_value(load_value),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.random_word(random_word),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.pready(pready),
		.mismatches(mismatches),
		.words_due(words_due)
	);

	// 12 ns clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// result-side backpressure: free runs, short stalls, now and then a long one
	always @(negedge clk) begin
		int pick;
		if (stall_hold == 0) begin
			pick = $urandom_range(0, 99);
			if (pick < 50) begin
				out_stall <= 1'b0;
				stall_hold = $urandom_range(1, 20);
			end else if (pick < 90) begin
				out_stall <= 1'b1;
				stall_hold = $urandom_range(1, 3);
			end else begin
				out_stall <= 1'b1;
				stall_hold = $urandom_range(10, 40);
			end
		end else begin
			stall_hold = stall_hold - 1;
		end
	end

	function automatic word_t rand_word();
		return {$urandom, $urandom};
	endfunction

	// one input transaction, preceded by a random gap; starts and ends at a falling edge
	task automatic push_item(input logic f, input logic [8:0] idx, input word_t val);
		int gap;
		int pick;
		pick = $urandom_range(0, 99);
		if (no_gaps || pick < 60) begin
			gap = 0;
		end else if (pick < 90) begin
			gap = $urandom_range(1, 3);
		end else begin
			gap = $urandom_range(5, 30);
		end
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		func <= f;
		word_index <= idx;
		load_value <= val;
		do @(posedge clk); while (in_stall);
		@(negedge clk);
	endtask

	// wait until every word has come out and any trailing load has retired
	task automatic settle();
		in_valid <= 1'b0;
		while (words_due != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	// apb write: setup cycle, access cycle, then the bus returns to idle
	task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 3'b000};
		pwdata <= data;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
	endtask

	task automatic program_generator(input logic [6:0] ww, input logic [8:0] mid,
			input logic [5:0] split, input logic [5:0] sl, input logic [5:0] sr,
			input word_t twist);
		settle();
		write_reg(REG_WORD_WIDTH, 64'(ww));
		write_reg(REG_MID_OFFSET, 64'(mid));
		write_reg(REG_SPLIT_BITS, 64'(split));
		write_reg(REG_LEFT_SHIFT, 64'(sl));
		write_reg(REG_RIGHT_SHIFT, 64'(sr));
		write_reg(REG_TWIST_CONSTANT, twist);
	endtask

	initial begin
		int load_pct;
		int pick;
		logic [8:0] idx;
		word_t val;
		arst_n = 1'b0;
		in_valid = 1'b0;
		func = FUNC_GEN;
		word_index = '0;
		load_value = '0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		repeat (8) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int phase = 0; phase < PHASES; phase++) begin
			// register setting for this phase, extremes first
			case (phase)
				0: program_generator(7'd64, 9'd81, 6'd19, 6'd36, 6'd21, rand_word());
				1: program_generator(7'd1, 9'd1, 6'd0, 6'd1, 6'd1, '1);
				2: program_generator(7'd0, 9'd310, 6'd63, 6'd63, 6'd63, rand_word());
				3: program_generator(7'd127, 9'd0, 6'd63, 6'd0, 6'd0, '1);
				4: program_generator(7'd32, 9'd511, 6'd16, 6'd5, 6'd27, rand_word());
				5: program_generator(7'd64, 9'd311, 6'd0, 6'd63, 6'd1, '0);
				6: program_generator(7'd17, 9'd150, 6'd17, 6'd3, 6'd0, rand_word());
				default: program_generator(7'($urandom_range(0, 127)),
					9'($urandom_range(0, 511)), 6'($urandom_range(0, 63)),
					6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)), rand_word());
			endcase
			no_gaps = ($urandom_range(0, 3) == 0);

			if (phase == 0) begin
				// seed every ring word and the extra word
				for (int k = 0; k < STATE_WORDS; k++) begin
					push_item(FUNC_LOAD, 9'(k), rand_word());
				end
				// directed: step a few words, then reseed the edges of the index range
				for (int k = 0; k < 3; k++) begin
					push_item(FUNC_GEN, 9'd0, '0);
				end
				// word zero drops its low split bits
				push_item(FUNC_LOAD, 9'd0, '1);
				// last index is the extra word
				push_item(FUNC_LOAD, 9'(RING_LEN), '1);
				push_item(FUNC_LOAD, 9'(RING_LEN - 1), '0);
				// indexes past the extra word only restart the ring position
				push_item(FUNC_LOAD, 9'(STATE_WORDS), '1);
				push_item(FUNC_LOAD, 9'd511, '0);
				for (int k = 0; k < 4; k++) begin
					push_item(FUNC_GEN, 9'd511, '1);
				end
				push_item(FUNC_LOAD, 9'd1, 64'h8000_0000_0000_0001);
				for (int k = 0; k < 4; k++) begin
					push_item(FUNC_GEN, 9'd0, '0);
				end
			end

			// random transactions: mostly generate runs, loads now and then
			case (phase % 3)
				0: load_pct = 0;
				1: load_pct = 2;
				default: load_pct = 12;
			endcase
			for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
				if ($urandom_range(0, 99) < load_pct) begin
					if ($urandom_range(0, 9) < 8) begin
						idx = 9'($urandom_range(0, RING_LEN));
					end else begin
						idx = 9'($urandom_range(STATE_WORDS, 511));
					end
					pick = $urandom_range(0, 9);
					if (pick == 0) begin
						val = '0;
					end else if (pick == 1) begin
						val = '1;
					end else begin
						val = rand_word();
					end
					push_item(FUNC_LOAD, idx, val);
				end else begin
					push_item(FUNC_GEN, 9'($urandom_range(0, 511)), rand_word());
				end
			end
		end

		settle();
		if (mismatches == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
